// ===== hdl/lgs_pkg.sv =====
// Shared types, constants and the Life rule for the generation step block.
`timescale 1ns / 1ps

package lgs_pkg;

    // Field widths fixed by the interface.
    localparam int CFG_W  = 7;
    localparam int POS_W  = 6;
    localparam int WIN_W  = 9;
    localparam int SEL_W  = 4;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Grid side after reset.
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

    // Which neighbor cell of the current input a result describes.
    localparam logic [1:0] RES_UP_LEFT = 2'd0;
    localparam logic [1:0] RES_UP      = 2'd1;
    localparam logic [1:0] RES_LEFT    = 2'd2;
    localparam logic [1:0] RES_HERE    = 2'd3;

    // One classified cell: its 3x3 window and the set of results it causes.
    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [SEL_W-1:0] sel;
    } job_ctl_t;

    // Next state of the window cell chosen by pick (B3/S23, outside is dead).
    // Window bit k*3+t holds column k (oldest first) and row t (top first).
    function automatic logic next_state(logic [WIN_W-1:0] win, logic [1:0] pick);
        int         kc;
        int         tc;
        logic [3:0] n;
        logic       ctr;
        kc  = 1 + int'(pick[0]);
        tc  = 1 + int'(pick[1]);
        n   = 4'd0;
        ctr = win[kc * 3 + tc];
        for (int k = 0; k < 3; k++)
        begin
            for (int t = 0; t < 3; t++)
            begin
                if ((k != kc || t != tc) && (k - kc <= 1) && (kc - k <= 1)
                    && (t - tc <= 1) && (tc - t <= 1))
                begin
                    n = n + 4'(win[k * 3 + t]);
                end
            end
        end
        return (n == 4'd3) || (n == 4'd2 && ctr);
    endfunction

endpackage

// ===== hdl/lgs_front.sv =====
// Front part: raster counters, line buffers, window and result classification.
`timescale 1ns / 1ps

module lgs_front #(
    parameter int NMAX = 64,
    parameter int CW   = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [lgs_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                     accept,
    input  logic                     alive,
    output logic                     job_push,
    output lgs_pkg::job_ctl_t        job_ctl,
    output logic [CW-1:0]            job_row,
    output logic [CW-1:0]            job_col
);

    localparam logic [lgs_pkg::CFG_W-1:0] NMAX_V = lgs_pkg::CFG_W'(NMAX);

    logic [lgs_pkg::CFG_W-1:0] grid_size_reg, grid_size_next;
    logic [CW-1:0]             row_reg, row_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [lgs_pkg::WIN_W-1:0] window_reg, window_next;
    logic [1:0]                pf_reg;
    logic [1:0]                lbuf_mem [NMAX];

    logic [lgs_pkg::CFG_W-1:0] side;
    logic [CW-1:0]             last;
    logic                      row_last, col_last;
    logic [CW-1:0]             col_adv, row_adv;
    logic                      top, mid;

    // Side in use, clamped to the supported range.
    always_comb
    begin
        if (grid_size_reg < 7'd2)
        begin
            side = 7'd2;
        end
        else if (grid_size_reg > NMAX_V)
        begin
            side = NMAX_V;
        end
        else
        begin
            side = grid_size_reg;
        end
        last = CW'(side - 7'd1);
    end

    assign row_last = (row_reg == last);
    assign col_last = (col_reg == last);
    assign col_adv  = col_last ? '0 : col_reg + CW'(1);
    assign row_adv  = row_last ? '0 : row_reg + CW'(1);

    // Stale line buffers read as dead: the upper one in the first two rows, the lower one in row 0.
    assign top = (row_reg >= CW'(2)) ? pf_reg[1] : 1'b0;
    assign mid = (row_reg != '0) ? pf_reg[0] : 1'b0;

    // Counter, window and register updates; a configuration write restarts the frame.
    always_comb
    begin
        grid_size_next = grid_size_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        window_next    = window_reg;
        if (cfg_we)
        begin
            grid_size_next = cfg_wdata;
            row_next       = '0;
            col_next       = '0;
            window_next    = '0;
        end
        else if (accept)
        begin
            col_next    = col_adv;
            row_next    = col_last ? row_adv : row_reg;
            window_next = job_ctl.window;
        end
    end

    // Window after shifting in the new column, and the results this cell releases.
    always_comb
    begin
        job_ctl.window = ((col_reg == '0) ? '0 : (window_reg >> 3))
                         | {alive, mid, top, 6'b0};
        job_ctl.sel[0] = (row_reg != '0) && (col_reg != '0);
        job_ctl.sel[1] = (row_reg != '0) && col_last;
        job_ctl.sel[2] = row_last && (col_reg != '0);
        job_ctl.sel[3] = row_last && col_last;
    end

    assign job_push = accept && (job_ctl.sel != '0);
    assign job_row  = row_reg;
    assign job_col  = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= lgs_pkg::GRID_SIZE_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            window_reg    <= '0;
        end
        else
        begin
            grid_size_reg <= grid_size_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            window_reg    <= window_next;
        end
    end

    // Line buffer memory: write this column, prefetch the next column for the next transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lbuf_mem[col_reg] <= {mid, alive};
            pf_reg            <= lbuf_mem[col_adv];
        end
    end

`ifndef SYNTHESIS
    // The column counter wraps after the last column of a row.
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && col_last |=> col_reg == '0)
        else $error("column counter did not wrap at row end");
`endif

endmodule

// ===== hdl/lgs_queue.sv =====
// Small job queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module lgs_queue #(
    parameter int DW    = 25,
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          wr, rd;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign dout  = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    // With both pointers equal the count tells full from empty; both at once is a slip.
    a_not_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty together");
`endif

endmodule

// ===== hdl/lgs_back.sv =====
// Back part: expands each job into its results and holds the output register.
`timescale 1ns / 1ps

module lgs_back #(
    parameter int CW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    output logic                      q_pop,
    input  lgs_pkg::job_ctl_t         q_ctl,
    input  logic [CW-1:0]             q_row,
    input  logic [CW-1:0]             q_col,
    input  logic                      pop,
    output logic                      empty,
    output logic                      next_alive,
    output logic [lgs_pkg::POS_W-1:0] cell_row,
    output logic [lgs_pkg::POS_W-1:0] cell_col,
    output logic                      frame_end,
    output logic                      run_last
);

    logic [lgs_pkg::WIN_W-1:0] win_reg;
    logic [lgs_pkg::SEL_W-1:0] pend_reg, pend_next;
    logic [CW-1:0]             row_reg, col_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      next_alive_reg;
    logic [lgs_pkg::POS_W-1:0] cell_row_reg, cell_col_reg;
    logic                      frame_end_reg, run_last_reg;

    logic                      advance, emit, load;
    logic [1:0]                pick;
    logic [lgs_pkg::SEL_W-1:0] pend_rest;

    // Oldest pending result of the current job goes first.
    always_comb
    begin
        priority if (pend_reg[0])
        begin
            pick = lgs_pkg::RES_UP_LEFT;
        end
        else if (pend_reg[1])
        begin
            pick = lgs_pkg::RES_UP;
        end
        else if (pend_reg[2])
        begin
            pick = lgs_pkg::RES_LEFT;
        end
        else
        begin
            pick = lgs_pkg::RES_HERE;
        end
    end

    assign pend_rest = pend_reg & ~(lgs_pkg::SEL_W'(1) << pick);
    assign advance   = !out_valid_reg || pop;
    assign emit      = advance && (pend_reg != '0);
    assign load      = !q_empty && ((pend_reg == '0) || (emit && pend_rest == '0));
    assign q_pop     = load;

    // Pending set and output valid updates.
    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            pend_next = q_ctl.sel;
        end
        else if (emit)
        begin
            pend_next = pend_rest;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job payload and result payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg <= q_ctl.window;
            row_reg <= q_row;
            col_reg <= q_col;
        end
        if (emit)
        begin
            next_alive_reg <= lgs_pkg::next_state(win_reg, pick);
            cell_row_reg   <= lgs_pkg::POS_W'(row_reg - (pick[1] ? CW'(0) : CW'(1)));
            cell_col_reg   <= lgs_pkg::POS_W'(col_reg - (pick[0] ? CW'(0) : CW'(1)));
            frame_end_reg  <= (pick == lgs_pkg::RES_HERE);
            run_last_reg   <= (pend_rest == '0);
        end
    end

    assign empty      = !out_valid_reg;
    assign next_alive = next_alive_reg;
    assign cell_row   = cell_row_reg;
    assign cell_col   = cell_col_reg;
    assign frame_end  = frame_end_reg;
    assign run_last   = run_last_reg;

`ifndef SYNTHESIS
    // The frame's last cell is always the final result of its item.
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> run_last_reg)
        else $error("frame end result not marked as last of its run");

    // Every job taken from the queue releases at least one result.
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> pend_reg != '0)
        else $error("job with no results reached the back part");
`endif

endmodule

// ===== hdl/life_generation_step.sv =====
// Top level of the streaming Life generation step (B3/S23).
// Each job goes through the job queue and the back part's job registers to the output register.
// Throughput: one cell per cycle in, one result per cycle out while the receiver pops; a row end
// below the first row releases 2 results, as does each later cell of the last row, its last cell 4.
// The front stalls only when the 4-entry job queue is full.
// Reset (rst_n low, asynchronous) empties queue and output, sets grid size 64, counters to zero.
`timescale 1ns / 1ps

module life_generation_step #(
    parameter int MAX_SIZE = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lgs_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  logic                      alive,
    output logic                      empty,
    input  logic                      pop,
    output logic                      next_alive,
    output logic [lgs_pkg::POS_W-1:0] cell_row,
    output logic [lgs_pkg::POS_W-1:0] cell_col,
    output logic                      frame_end,
    output logic                      run_last
);

    // The 7-bit grid size register also bounds the usable side.
    localparam int NMAX = (MAX_SIZE < 127) ? MAX_SIZE : 127;
    localparam int CW   = $clog2(NMAX);
    localparam int DW   = lgs_pkg::WIN_W + lgs_pkg::SEL_W + 2 * CW;

    logic                  accept;
    logic                  job_push;
    lgs_pkg::job_ctl_t     job_ctl, q_ctl;
    logic [CW-1:0]         job_row, job_col, q_row, q_col;
    logic                  q_empty, q_pop;
    logic [DW-1:0]         q_din, q_dout;

    assign accept = push && !full;
    assign q_din  = {job_ctl, job_row, job_col};
    assign {q_ctl, q_row, q_col} = q_dout;

    lgs_front #(
        .NMAX (NMAX),
        .CW   (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .alive     (alive),
        .job_push  (job_push),
        .job_ctl   (job_ctl),
        .job_row   (job_row),
        .job_col   (job_col)
    );

    lgs_queue #(
        .DW    (DW),
        .DEPTH (lgs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (q_din),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    lgs_back #(
        .CW (CW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_ctl      (q_ctl),
        .q_row      (q_row),
        .q_col      (q_col),
        .pop        (pop),
        .empty      (empty),
        .next_alive (next_alive),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .frame_end  (frame_end),
        .run_last   (run_last)
    );

endmodule

// ===== tb/tb_life_generation_step.sv =====
// Self-checking testbench for the streaming Life generation step block.
`timescale 1ns / 1ps

module tb_life_generation_step;

    localparam int GRID_MAX    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 80;
    localparam int PRINT_CAP   = 50;

    typedef enum {STEADY, SENDER_GAPS, RECEIVER_STALLS, BOTH_IDLE} idling_t;

    // One predicted next-generation cell, in the order of the result ports.
    typedef struct packed {
        logic                      next_alive;
        logic [lgs_pkg::POS_W-1:0] row;
        logic [lgs_pkg::POS_W-1:0] col;
        logic                      frame_end;
        logic                      run_last;
    } life_cell_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [lgs_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic                      alive = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic                      next_alive;
    logic [lgs_pkg::POS_W-1:0] cell_row;
    logic [lgs_pkg::POS_W-1:0] cell_col;
    logic                      frame_end;
    logic                      run_last;

    // Stimulus and checking state.
    logic       cells_q[$];
    life_cell_t future_q[$];
    bit         cell_sent = 1'b0;
    int         send_gap_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_on = 1'b0;
    int         hold_len = 0;
    int         errors = 0;
    int         cycle_count = 0;

    // Shadow copy of the block state.
    logic [lgs_pkg::CFG_W-1:0] grid_reg = lgs_pkg::GRID_SIZE_RESET;
    logic                      line_up[GRID_MAX];
    logic                      line_up2[GRID_MAX];
    logic [lgs_pkg::WIN_W-1:0] win_bits = '0;
    int                        row_idx = 0;
    int                        col_idx = 0;

    life_generation_step #(.MAX_SIZE(GRID_MAX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .alive     (alive),
        .empty     (empty),
        .pop       (pop),
        .next_alive(next_alive),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

    always #10 clk = ~clk;

    initial
    begin
        for (int i = 0; i < GRID_MAX; i++)
        begin
            line_up[i]  = 1'b0;
            line_up2[i] = 1'b0;
        end
    end

    // Grid side in use, with out-of-range settings clamped.
    function automatic int grid_side();
        if (grid_reg < 2)
            return 2;
        if (grid_reg > GRID_MAX)
            return GRID_MAX;
        return int'(grid_reg);
    endfunction

    // B3/S23 rule for window column k and row t; cells off the window are dead.
    function automatic logic life_rule(logic [lgs_pkg::WIN_W-1:0] w, int k, int t);
        int n;
        int kk;
        int tt;
        n = 0;
        for (int dk = -1; dk <= 1; dk++)
        begin
            for (int dt = -1; dt <= 1; dt++)
            begin
                kk = k + dk;
                tt = t + dt;
                if ((dk != 0 || dt != 0) && kk >= 0 && kk <= 2 && tt >= 0 && tt <= 2)
                    n += int'(w[kk * 3 + tt]);
            end
        end
        return (n == 3) || (n == 2 && w[k * 3 + t]);
    endfunction

    function automatic life_cell_t make_cell(logic v, int r, int c, logic fe);
        life_cell_t res;
        res.next_alive = v;
        res.row        = lgs_pkg::POS_W'(r);
        res.col        = lgs_pkg::POS_W'(c);
        res.frame_end  = fe;
        res.run_last   = 1'b0;
        return res;
    endfunction

    // Advance the shadow state by one cell and queue the cells it completes.
    task automatic evolve_cell(input logic a);
        int         n;
        int         r;
        int         c;
        int         cnt;
        logic       top;
        logic       mid;
        life_cell_t done[4];
        n   = grid_side();
        r   = row_idx;
        c   = col_idx;
        cnt = 0;
        if (r >= n || c >= n)
        begin
            r = 0;
            c = 0;
        end

        // Stale line buffers read as dead: the upper one in the first two rows, the lower one in row 0.
        top = (r >= 2) ? line_up2[c] : 1'b0;
        mid = (r >= 1) ? line_up[c] : 1'b0;
        line_up2[c] = mid;
        line_up[c]  = a;

        // Shift the window one column and load the new column at the top end.
        if (c == 0)
            win_bits = '0;
        else
            win_bits = win_bits >> 3;
        win_bits[8:6] = {a, mid, top};

        if (r >= 1 && c >= 1)
        begin
            done[cnt] = make_cell(life_rule(win_bits, 1, 1), r - 1, c - 1, 1'b0);
            cnt++;
        end
        if (r >= 1 && c == n - 1)
        begin
            done[cnt] = make_cell(life_rule(win_bits, 2, 1), r - 1, c, 1'b0);
            cnt++;
        end
        if (r == n - 1 && c >= 1)
        begin
            done[cnt] = make_cell(life_rule(win_bits, 1, 2), r, c - 1, 1'b0);
            cnt++;
        end
        if (r == n - 1 && c == n - 1)
        begin
            done[cnt] = make_cell(life_rule(win_bits, 2, 2), r, c, 1'b1);
            cnt++;
        end
        for (int i = 0; i < cnt; i++)
        begin
            if (i == cnt - 1)
                done[i].run_last = 1'b1;
            future_q.push_back(done[i]);
        end

        // Raster counters wrap at the end of the frame.
        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        row_idx = r;
        col_idx = c;
    endtask

    task automatic report_mismatch(input string what);
        if (errors < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        errors++;
    endtask

    // Monitor: follows register writes and input transfers, checks result transfers.
    always @(posedge clk)
    begin
        life_cell_t got;
        life_cell_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                grid_reg = cfg_wdata;
                win_bits = '0;
                row_idx  = 0;
                col_idx  = 0;
            end
            if (!empty && pop)
            begin
                got = '{next_alive, cell_row, cell_col, frame_end, run_last};
                if (future_q.size() == 0)
                begin
                    report_mismatch($sformatf("result for (%0d,%0d) with none predicted",
                                              cell_row, cell_col));
                end
                else
                begin
                    want = future_q.pop_front();
                    if (got.next_alive != want.next_alive)
                        report_mismatch($sformatf("next_alive %0d, want %0d at (%0d,%0d)",
                                        got.next_alive, want.next_alive, want.row, want.col));
                    if (got.row != want.row)
                        report_mismatch($sformatf("cell_row %0d, want %0d",
                                                  got.row, want.row));
                    if (got.col != want.col)
                        report_mismatch($sformatf("cell_col %0d, want %0d",
                                                  got.col, want.col));
                    if (got.frame_end != want.frame_end)
                        report_mismatch($sformatf("frame_end %0d, want %0d at (%0d,%0d)",
                                        got.frame_end, want.frame_end, want.row, want.col));
                    if (got.run_last != want.run_last)
                        report_mismatch($sformatf("run_last %0d, want %0d at (%0d,%0d)",
                                        got.run_last, want.run_last, want.row, want.col));
                end
            end
            cell_sent = push && !full;
            if (cell_sent)
                evolve_cell(alive);
        end
    end

    // Cell driver: holds an offered cell until its transfer, else offers the next one.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (push && !cell_sent)
        begin
            // Still waiting for the transfer of the offered cell.
            push <= 1'b1;
        end
        else if (cells_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
        begin
            push  <= 1'b1;
            alive <= cells_q.pop_front();
        end
        else
        begin
            push  <= 1'b0;
            alive <= 1'($urandom_range(1));
        end
    end

    // Result side: random stalls, and a forced hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    // Length of the current hold-off in cycles.
    always @(negedge clk)
    begin
        if (hold_on)
            hold_len <= hold_len + 1;
        else
            hold_len <= 0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic set_idling(input idling_t mode);
        unique case (mode)
            STEADY:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            SENDER_GAPS:
            begin
                send_gap_pct   = 45;
                recv_stall_pct = 0;
            end
            RECEIVER_STALLS:
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 45;
            end
            BOTH_IDLE:
            begin
                send_gap_pct   = 37;
                recv_stall_pct = 37;
            end
        endcase
    endtask

    // Wait until every cell is transferred and every predicted cell has come out.
    task automatic wait_drained();
        while (cells_q.size() != 0 || push)
            @(posedge clk);
        while (future_q.size() != 0)
            @(negedge clk);
    endtask

    // Write the grid size once the block is idle; returns at a rising edge.
    task automatic program_size(input int side_val);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lgs_pkg::CFG_W'(side_val);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Queue cells given as a bit string in raster order, first cell leftmost.
    task automatic queue_bits(input logic [15:0] bits, input int len);
        for (int i = len - 1; i >= 0; i--)
            cells_q.push_back(bits[i]);
    endtask

    task automatic queue_random(input int count, input int density);
        for (int i = 0; i < count; i++)
            cells_q.push_back($urandom_range(99) < density);
    endtask

    // Full frames with random content at a given size and idling mode.
    task automatic run_frames(input int side_val, input int frames, input idling_t mode);
        int n;
        program_size(side_val);
        set_idling(mode);
        n = (side_val < 2) ? 2 : ((side_val > GRID_MAX) ? GRID_MAX : side_val);
        for (int f = 0; f < frames; f++)
            queue_random(n * n, $urandom_range(15, 60));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size: a few cells of the first row release nothing.
        queue_bits(16'b101, 3);

        // Smallest grid (0 clamps to 2): a stable block, then a second frame over
        // stale line buffers.
        program_size(0);
        queue_bits(16'b1111, 4);
        queue_bits(16'b1001, 4);

        // Blinker on a 3x3 grid turns from vertical to horizontal.
        program_size(3);
        queue_bits(16'b010_010_010, 9);

        // Size 1 clamps to 2: three live cells give birth to the fourth.
        program_size(1);
        queue_bits(16'b1101, 4);

        // Random frames across sizes and idling modes.
        run_frames(2, 3, STEADY);
        run_frames(4, 2, SENDER_GAPS);
        run_frames(5, 1, RECEIVER_STALLS);
        run_frames(3, 4, BOTH_IDLE);

        // Full-size grid, partial frame: hold the result side off so the block fills.
        program_size(GRID_MAX);
        set_idling(STEADY);
        queue_random(100, 40);
        while (cells_q.size() > 30)
            @(posedge clk);
        hold_on = 1'b1;
        while (hold_len < HOLD_CYCLES)
            @(posedge clk);
        hold_on = 1'b0;

        // Largest register value clamps to the full size; one row and a bit.
        program_size(127);
        set_idling(BOTH_IDLE);
        queue_random(66, 50);

        run_frames(6, 1, BOTH_IDLE);

        // Broken frame: restarted by the next write before it completes.
        program_size(7);
        set_idling(SENDER_GAPS);
        queue_random(20, 50);
        program_size(2);
        set_idling(RECEIVER_STALLS);
        queue_random(8, 50);

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
